// File: src/bed_pkg.sv
// shared types, constants and register indexes of the button event detector
`default_nettype none

package bed_pkg;

    localparam int NUM_KEYS      = 8;
    localparam int KEY_W         = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int QUEUE_DEPTH   = 16;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CODES_PER_KEY = 8;
    localparam int CODE_W        = 6;
    localparam int KIND_W        = 4;
    localparam int LEVELS_W      = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HITS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_MASK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET      = 3'd6;

    localparam logic [KIND_W-1:0] KIND_PRESS      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LONG       = 4'd2;
    localparam logic [KIND_W-1:0] KIND_REPEAT     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_CLICK_BASE = 4'd3;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic [7:0]  debounce;
        logic        key_down;
        logic        long_flag;
        logic [15:0] hold;
        logic [15:0] rpt;
        logic [2:0]  click;
        logic        win_run;
        logic [15:0] win_cnt;
    } key_state_t;

    typedef struct packed {
        logic [7:0]  filter;
        logic [15:0] long_press;
        logic [15:0] rpt_ticks;
        logic [15:0] combo;
        logic [2:0]  max_hits;
        logic [7:0]  rpt_mask;
        logic        quiet;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KREAD,
        ST_KCALC,
        ST_PUSH,
        ST_RD
    } state_t;

endpackage

`default_nettype wire

// File: src/bed_if.sv
// handshake interfaces for the command, event and configuration channels
`default_nettype none

interface bed_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [bed_pkg::LEVELS_W-1:0]  key_levels;

    modport source (output valid, output func, output key_levels, input ready);
    modport sink   (input valid, input func, input key_levels, output ready);
endinterface

interface bed_evt_if;
    logic                        valid;
    logic                        ready;
    logic                        event_valid;
    logic [bed_pkg::CODE_W-1:0]  event_code;

    modport source (output valid, output event_valid, output event_code, input ready);
    modport sink   (input valid, input event_valid, input event_code, output ready);
endinterface

interface bed_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bed_pkg::CFG_IDX_W-1:0]   index;
    logic [bed_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/button_event_detector.sv
// button event detector: per-key debounce, long press, repeat, multi-click, event queue
//
// A tick beat (func 0) walks the keys one after another through a per-key state memory:
// each key passes a read state (KREAD) and an update state (KCALC), plus a visit to the
// push state (PUSH) for each event it pushes. Only the one key that is pressed alone can
// push three events (press or click, long, repeat), and every other key pushes at most a
// release; the next beat is not taken until the walk over all keys is done. A read beat
// (func 1) pops one event from the queue memory into the output register, or gives a
// result with no event when the queue is empty; it waits while the previous result is still held.
// Events are dropped when the queue, which holds QUEUE_DEPTH-1 entries, is full.
// Configuration writes are always ready.
`default_nettype none

module button_event_detector (
    input  wire       clk,
    input  wire       rst_n,
    bed_cmd_if.sink   cmd,
    bed_evt_if.source evt,
    bed_cfg_if.sink   cfg
);

    localparam int NK = bed_pkg::NUM_KEYS;
    localparam int KW = bed_pkg::KEY_W;
    localparam int QW = bed_pkg::QPTR_W;
    localparam int CW = bed_pkg::CODE_W;

    bed_pkg::state_t     state_reg, state_next;
    bed_pkg::cfg_t       cfg_reg, cfg_next;
    logic [KW-1:0]       key_idx_reg, key_idx_next;
    logic [QW-1:0]       wr_pos_reg, wr_pos_next;
    logic [QW-1:0]       rd_pos_reg, rd_pos_next;
    logic [NK-1:0]       st_valid_reg, st_valid_next;
    logic [2:0]          pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;

    logic [bed_pkg::LEVELS_W-1:0] levels_reg, levels_next;
    logic [CW-1:0]       ev_code_reg [3];
    logic [CW-1:0]       ev_code_next [3];
    logic                out_ev_valid_reg, out_ev_valid_next;
    logic [CW-1:0]       out_code_reg, out_code_next;

    bed_pkg::key_state_t st_mem [NK];
    bed_pkg::key_state_t st_rd_reg;
    logic                st_we;
    bed_pkg::key_state_t st_wdata;

    logic [CW-1:0]       ev_mem [bed_pkg::QUEUE_DEPTH];
    logic [CW-1:0]       ev_rd_reg;
    logic                push_fire;
    logic [CW-1:0]       push_code;
    logic [QW-1:0]       wr_pos_inc;
    logic [QW-1:0]       rd_pos_inc;
    logic [2:0]          hit_limit;

    assign cmd.ready       = (state_reg == bed_pkg::ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign evt.valid       = out_valid_reg;
    assign evt.event_valid = out_ev_valid_reg;
    assign evt.event_code  = out_code_reg;

    assign wr_pos_inc = (wr_pos_reg == QW'(bed_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_pos_reg + 1'b1;
    assign rd_pos_inc = (rd_pos_reg == QW'(bed_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_pos_reg + 1'b1;

    always_comb
    begin
        if (cfg_reg.max_hits < 3'd2)
        begin
            hit_limit = 3'd2;
        end
        else if (cfg_reg.max_hits > 3'd5)
        begin
            hit_limit = 3'd5;
        end
        else
        begin
            hit_limit = cfg_reg.max_hits;
        end
    end

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                bed_pkg::CFG_FILTER:     cfg_next.filter     = cfg.data[7:0];
                bed_pkg::CFG_LONG_PRESS: cfg_next.long_press = cfg.data;
                bed_pkg::CFG_RPT_TICKS:  cfg_next.rpt_ticks  = cfg.data;
                bed_pkg::CFG_COMBO:      cfg_next.combo      = cfg.data;
                bed_pkg::CFG_MAX_HITS:   cfg_next.max_hits   = cfg.data[2:0];
                bed_pkg::CFG_RPT_MASK:   cfg_next.rpt_mask   = cfg.data[7:0];
                bed_pkg::CFG_QUIET:      cfg_next.quiet      = cfg.data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // sequencer and per-key update
    always_comb
    begin : seq
        bed_pkg::key_state_t       s;
        bed_pkg::key_state_t       n;
        logic                      pressed;
        logic [2:0]                pend;
        logic [bed_pkg::KIND_W-1:0] kind [3];
        logic                      advance;

        state_next        = state_reg;
        key_idx_next      = key_idx_reg;
        wr_pos_next       = wr_pos_reg;
        rd_pos_next       = rd_pos_reg;
        st_valid_next     = st_valid_reg;
        pend_next         = pend_reg;
        out_valid_next    = out_valid_reg;
        levels_next       = levels_reg;
        ev_code_next      = ev_code_reg;
        out_ev_valid_next = out_ev_valid_reg;
        out_code_next     = out_code_reg;
        st_we             = 1'b0;
        push_fire         = 1'b0;
        push_code         = '0;
        advance           = 1'b0;

        s       = st_valid_reg[key_idx_reg] ? st_rd_reg : '0;
        n       = s;
        pend    = '0;
        kind[0] = bed_pkg::KIND_PRESS;
        kind[1] = bed_pkg::KIND_LONG;
        kind[2] = bed_pkg::KIND_REPEAT;
        pressed = $onehot(levels_reg) && (int'(key_idx_reg) < bed_pkg::LEVELS_W)
                  && levels_reg[key_idx_reg];

        if (pressed)
        begin
            if (s.debounce < cfg_reg.filter)
            begin
                n.debounce = s.debounce + 8'd1;
            end
            else
            begin
                if (!s.key_down)
                begin
                    n.key_down = 1'b1;
                    if (n.win_run)
                    begin
                        n.click   = n.click + 3'd1;
                        n.win_run = 1'b0;
                        n.win_cnt = '0;
                    end
                    pend[0] = 1'b1;
                    if (n.click != 3'd0)
                    begin
                        kind[0] = bed_pkg::KIND_CLICK_BASE + {1'b0, n.click};
                        if ({1'b0, n.click} + 4'd1 == {1'b0, hit_limit})
                        begin
                            n.click = '0;
                        end
                    end
                end
                if (s.hold < cfg_reg.long_press)
                begin
                    n.hold = s.hold + 16'd1;
                end
                else if (!s.long_flag)
                begin
                    n.long_flag = 1'b1;
                    pend[1]     = 1'b1;
                end
                if (cfg_reg.rpt_mask[key_idx_reg] && n.long_flag)
                begin
                    if (s.rpt < cfg_reg.rpt_ticks)
                    begin
                        n.rpt = s.rpt + 16'd1;
                    end
                    else
                    begin
                        n.rpt   = '0;
                        pend[2] = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (s.debounce != 8'd0)
            begin
                n.debounce = s.debounce - 8'd1;
            end
            else
            begin
                if (s.key_down)
                begin
                    n.win_cnt  = '0;
                    n.win_run  = 1'b1;
                    n.key_down = 1'b0;
                    if (!(cfg_reg.quiet && s.click != 3'd0))
                    begin
                        pend[0] = 1'b1;
                        kind[0] = bed_pkg::KIND_RELEASE;
                    end
                end
                n.long_flag = 1'b0;
                n.hold      = '0;
                n.rpt       = '0;
            end
        end

        // combo window
        if (n.win_run)
        begin
            n.win_cnt = n.win_cnt + 16'd1;
            if (n.win_cnt == cfg_reg.combo)
            begin
                n.win_run = 1'b0;
                n.win_cnt = '0;
                n.click   = '0;
            end
        end

        st_wdata = n;

        // output register drains independently
        if (out_valid_reg && evt.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bed_pkg::ST_IDLE:
            begin
                key_idx_next = '0;
                if (cmd.valid)
                begin
                    levels_next = cmd.key_levels;
                    state_next  = (cmd.func == bed_pkg::FUNC_READ) ? bed_pkg::ST_RD
                                                                   : bed_pkg::ST_KREAD;
                end
            end
            bed_pkg::ST_KREAD:
            begin
                state_next = bed_pkg::ST_KCALC;
            end
            bed_pkg::ST_KCALC:
            begin
                st_we                      = 1'b1;
                st_valid_next[key_idx_reg] = 1'b1;
                pend_next                  = pend;
                for (int i = 0; i < 3; i++)
                begin
                    ev_code_next[i] = CW'(int'(key_idx_reg) * bed_pkg::CODES_PER_KEY
                                          + int'(kind[i]));
                end
                if (pend != 3'b000)
                begin
                    state_next = bed_pkg::ST_PUSH;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            bed_pkg::ST_PUSH:
            begin
                if (pend_reg[0])
                begin
                    push_code    = ev_code_reg[0];
                    pend_next[0] = 1'b0;
                end
                else if (pend_reg[1])
                begin
                    push_code    = ev_code_reg[1];
                    pend_next[1] = 1'b0;
                end
                else
                begin
                    push_code    = ev_code_reg[2];
                    pend_next[2] = 1'b0;
                end
                if (wr_pos_inc != rd_pos_reg)
                begin
                    push_fire   = 1'b1;
                    wr_pos_next = wr_pos_inc;
                end
                if (pend_next == 3'b000)
                begin
                    advance = 1'b1;
                end
            end
            bed_pkg::ST_RD:
            begin
                if (!out_valid_reg || evt.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = bed_pkg::ST_IDLE;
                    if (rd_pos_reg == wr_pos_reg)
                    begin
                        out_ev_valid_next = 1'b0;
                        out_code_next     = '0;
                    end
                    else
                    begin
                        out_ev_valid_next = 1'b1;
                        out_code_next     = ev_rd_reg;
                        rd_pos_next       = rd_pos_inc;
                    end
                end
            end
            default:
            begin
                state_next = bed_pkg::ST_IDLE;
            end
        endcase

        if (advance)
        begin
            if (key_idx_reg == KW'(NK - 1))
            begin
                state_next = bed_pkg::ST_IDLE;
            end
            else
            begin
                key_idx_next = key_idx_reg + 1'b1;
                state_next   = bed_pkg::ST_KREAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bed_pkg::ST_IDLE;
            cfg_reg       <= '{filter: 8'd2, long_press: 16'd100, rpt_ticks: 16'd10,
                               combo: 16'd30, max_hits: 3'd4, rpt_mask: 8'd0, quiet: 1'b0};
            key_idx_reg   <= '0;
            wr_pos_reg    <= '0;
            rd_pos_reg    <= '0;
            st_valid_reg  <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            key_idx_reg   <= key_idx_next;
            wr_pos_reg    <= wr_pos_next;
            rd_pos_reg    <= rd_pos_next;
            st_valid_reg  <= st_valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        levels_reg       <= levels_next;
        ev_code_reg      <= ev_code_next;
        out_ev_valid_reg <= out_ev_valid_next;
        out_code_reg     <= out_code_next;
    end

    // per-key state memory
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[key_idx_reg] <= st_wdata;
        end
        st_rd_reg <= st_mem[key_idx_reg];
    end

    // event queue memory
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            ev_mem[wr_pos_reg] <= push_code;
        end
        ev_rd_reg <= ev_mem[rd_pos_reg];
    end

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire |=> (wr_pos_reg != rd_pos_reg))
        else $error("queue push left write and read positions equal");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == bed_pkg::ST_RD))
        else $error("result raised outside a read");

    a_calc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bed_pkg::ST_KCALC) |-> ($past(state_reg) == bed_pkg::ST_KREAD))
        else $error("key update without a preceding memory read");

    a_push_has_event: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bed_pkg::ST_PUSH) |-> (pend_reg != 3'b000))
        else $error("push cycle with no pending event");

endmodule

`default_nettype wire

// File: test/button_event_detector_tb.sv
// testbench for button_event_detector: directed and random key gestures checked beat by beat
module button_event_detector_tb;

    localparam int NUM_KEYS      = bed_pkg::NUM_KEYS;
    localparam int QUEUE_DEPTH   = bed_pkg::QUEUE_DEPTH;
    localparam int QPTR_W        = bed_pkg::QPTR_W;
    localparam int CODES_PER_KEY = bed_pkg::CODES_PER_KEY;
    localparam int CODE_W        = bed_pkg::CODE_W;
    localparam int LEVELS_W      = bed_pkg::LEVELS_W;
    localparam int CFG_IDX_W     = bed_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = bed_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RUN_LIMIT       = 4000000;

    typedef struct packed {
        logic                func;
        logic [LEVELS_W-1:0] levels;
    } cmd_beat_t;

    typedef struct packed {
        logic              ev_valid;
        logic [CODE_W-1:0] code;
    } key_event_t;

    logic clk = 1'b0;
    logic rst_n;

    bed_cmd_if cmd_ch ();
    bed_evt_if evt_ch ();
    bed_cfg_if cfg_ch ();

    button_event_detector dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .evt   (evt_ch),
        .cfg   (cfg_ch)
    );

    // mirror of the block state
    bed_pkg::cfg_t       cfg_now;
    bed_pkg::key_state_t keys [NUM_KEYS];
    logic [CODE_W-1:0]   event_ring [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   ring_wr;
    logic [QPTR_W-1:0]   ring_rd;

    key_event_t expected_events [$];
    cmd_beat_t  pending_beats [$];
    cmd_beat_t  cur_beat;

    int err_count     = 0;
    int items_made    = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    bit steady        = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    task automatic queue_event(input int k, input int kind);
        logic [QPTR_W-1:0] nxt;
        nxt = ring_wr + 1'b1;
        if (nxt != ring_rd)
        begin
            event_ring[ring_wr] = CODE_W'(k * CODES_PER_KEY + kind);
            ring_wr = nxt;
        end
    endtask

    function automatic int hits_limit();
        if (cfg_now.max_hits < 3'd2)
            return 2;
        if (cfg_now.max_hits > 3'd5)
            return 5;
        return int'(cfg_now.max_hits);
    endfunction

    task automatic accept_press(input int k);
        if (keys[k].win_run)
        begin
            keys[k].click   = keys[k].click + 3'd1;
            keys[k].win_run = 1'b0;
            keys[k].win_cnt = '0;
        end
        if (keys[k].click != 3'd0)
        begin
            queue_event(k, int'(bed_pkg::KIND_CLICK_BASE) + int'(keys[k].click));
            if (int'(keys[k].click) + 1 == hits_limit())
                keys[k].click = '0;
        end
        else
            queue_event(k, int'(bed_pkg::KIND_PRESS));
    endtask

    task automatic scan_key(input int k, input bit pressed);
        if (pressed)
        begin
            if (keys[k].debounce < cfg_now.filter)
                keys[k].debounce = keys[k].debounce + 8'd1;
            else
            begin
                if (!keys[k].key_down)
                begin
                    keys[k].key_down = 1'b1;
                    accept_press(k);
                end
                if (keys[k].hold < cfg_now.long_press)
                    keys[k].hold = keys[k].hold + 16'd1;
                else if (!keys[k].long_flag)
                begin
                    keys[k].long_flag = 1'b1;
                    queue_event(k, int'(bed_pkg::KIND_LONG));
                end
                if (k < LEVELS_W && cfg_now.rpt_mask[k] && keys[k].long_flag)
                begin
                    if (keys[k].rpt < cfg_now.rpt_ticks)
                        keys[k].rpt = keys[k].rpt + 16'd1;
                    else
                    begin
                        keys[k].rpt = '0;
                        queue_event(k, int'(bed_pkg::KIND_REPEAT));
                    end
                end
            end
        end
        else
        begin
            if (keys[k].debounce != 8'd0)
                keys[k].debounce = keys[k].debounce - 8'd1;
            else
            begin
                if (keys[k].key_down)
                begin
                    keys[k].win_cnt  = '0;
                    keys[k].win_run  = 1'b1;
                    keys[k].key_down = 1'b0;
                    if (!(cfg_now.quiet && keys[k].click != 3'd0))
                        queue_event(k, int'(bed_pkg::KIND_RELEASE));
                end
                keys[k].long_flag = 1'b0;
                keys[k].hold      = '0;
                keys[k].rpt       = '0;
            end
        end
    endtask

    task automatic run_window(input int k);
        if (keys[k].win_run)
        begin
            keys[k].win_cnt = keys[k].win_cnt + 16'd1;
            if (keys[k].win_cnt == cfg_now.combo)
            begin
                keys[k].win_run = 1'b0;
                keys[k].win_cnt = '0;
                keys[k].click   = '0;
            end
        end
    endtask

    task automatic predict_beat(input cmd_beat_t b);
        int n_down;
        int active;
        key_event_t popped;
        if (b.func == bed_pkg::FUNC_TICK)
        begin
            n_down = 0;
            active = 0;
            for (int k = 0; k < NUM_KEYS; k++)
                if (k < LEVELS_W && b.levels[k])
                begin
                    n_down++;
                    active = k;
                end
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                scan_key(k, n_down == 1 && active == k);
                run_window(k);
            end
        end
        else
        begin
            popped = '0;
            if (ring_rd != ring_wr)
            begin
                popped.ev_valid = 1'b1;
                popped.code     = event_ring[ring_rd];
                ring_rd         = ring_rd + 1'b1;
            end
            expected_events.push_back(popped);
        end
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        case (idx)
            bed_pkg::CFG_FILTER:     cfg_now.filter     = val[7:0];
            bed_pkg::CFG_LONG_PRESS: cfg_now.long_press = val;
            bed_pkg::CFG_RPT_TICKS:  cfg_now.rpt_ticks  = val;
            bed_pkg::CFG_COMBO:      cfg_now.combo      = val;
            bed_pkg::CFG_MAX_HITS:   cfg_now.max_hits   = val[2:0];
            bed_pkg::CFG_RPT_MASK:   cfg_now.rpt_mask   = val[7:0];
            bed_pkg::CFG_QUIET:      cfg_now.quiet      = val[0];
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg(idx, val);
        cfg_ch.valid <= 1'b0;
    endtask

    // unused upper data bits carry random junk
    task automatic set_config(input int f, input int lp, input int rt, input int cw,
                              input int mh, input int mask, input int q);
        write_reg(bed_pkg::CFG_FILTER,     {8'($urandom), 8'(f)});
        write_reg(bed_pkg::CFG_LONG_PRESS, 16'(lp));
        write_reg(bed_pkg::CFG_RPT_TICKS,  16'(rt));
        write_reg(bed_pkg::CFG_COMBO,      16'(cw));
        write_reg(bed_pkg::CFG_MAX_HITS,   {13'($urandom), 3'(mh)});
        write_reg(bed_pkg::CFG_RPT_MASK,   {8'($urandom), 8'(mask)});
        write_reg(bed_pkg::CFG_QUIET,      {15'($urandom), 1'(q)});
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_SPARE, 16'($urandom));
    endtask

    task automatic add_beat(input logic func, input logic [LEVELS_W-1:0] levels);
        cmd_beat_t b;
        b.func   = func;
        b.levels = levels;
        pending_beats.push_back(b);
        items_made++;
    endtask

    task automatic add_reads(input int n);
        repeat (n)
            add_beat(bed_pkg::FUNC_READ, LEVELS_W'($urandom));
    endtask

    task automatic add_ticks(input logic [LEVELS_W-1:0] levels, input int n,
                             input int read_pct);
        repeat (n)
        begin
            add_beat(bed_pkg::FUNC_TICK, levels);
            if ($urandom_range(0, 99) < read_pct)
                add_reads(1);
        end
    endtask

    task automatic add_gesture(input int read_pct);
        int pick;
        int k;
        int k2;
        int hold;
        int gap;
        int win;
        int filt;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, NUM_KEYS - 1);
        filt = int'(cfg_now.filter);
        win  = (cfg_now.combo == 16'd0 || cfg_now.combo > 16'd40) ? 40 : int'(cfg_now.combo);
        if (pick < 70)
        begin
            // press and release runs, several in a row for multi-click
            repeat (($urandom_range(0, 2) == 0) ? $urandom_range(2, 6) : 1)
            begin
                if ($urandom_range(0, 3) == 0 && cfg_now.long_press < 16'd60)
                    hold = filt + int'(cfg_now.long_press) + $urandom_range(1, 25);
                else
                    hold = filt + $urandom_range(1, 4);
                if (hold > 80)
                    hold = $urandom_range(1, 80);
                gap = filt + $urandom_range(0, win) + $urandom_range(0, 3);
                if (gap > 80)
                    gap = $urandom_range(0, 80);
                add_ticks(LEVELS_W'(1 << k), hold, read_pct);
                add_ticks('0, gap, read_pct);
            end
        end
        else if (pick < 80)
            add_ticks(LEVELS_W'($urandom), $urandom_range(1, 3), read_pct);
        else if (pick < 90)
        begin
            k2 = (k + $urandom_range(1, NUM_KEYS - 1)) % NUM_KEYS;
            add_ticks(LEVELS_W'((1 << k) | (1 << k2)), $urandom_range(1, 3), read_pct);
        end
        else
            add_reads($urandom_range(1, 4));
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || cmd_ch.valid || expected_events.size() != 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_phase(input int n_items, input int read_pct);
        int start;
        start = items_made;
        while (items_made - start < n_items)
            add_gesture(read_pct);
        add_reads(QUEUE_DEPTH);
        wait_idle();
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid      <= 1'b0;
            cmd_ch.func       <= bed_pkg::FUNC_TICK;
            cmd_ch.key_levels <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                predict_beat(cur_beat);
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (pending_beats.size() != 0 && (steady || $urandom_range(0, 99) >= 25))
                begin
                    cur_beat           = pending_beats.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.func       <= cur_beat.func;
                    cmd_ch.key_levels <= cur_beat.levels;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // event monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin : evt_monitor
        key_event_t want;
        if (!rst_n)
            evt_ch.ready <= 1'b0;
        else
        begin
            if (evt_ch.valid && evt_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    err_count++;
                    $display("%0t: event beat with nothing expected: valid %0b code %0d",
                             $time, evt_ch.event_valid, evt_ch.event_code);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (evt_ch.event_valid !== want.ev_valid)
                    begin
                        err_count++;
                        $display("%0t: event_valid expected %0b actual %0b",
                                 $time, want.ev_valid, evt_ch.event_valid);
                    end
                    if (evt_ch.event_code !== want.code)
                    begin
                        err_count++;
                        $display("%0t: event_code expected %0d actual %0d",
                                 $time, want.code, evt_ch.event_code);
                    end
                end
            end
            if (hold_left == 0 && holds_done < hold_requests)
            begin
                hold_left = HOLD_OFF_CYCLES;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                evt_ch.ready <= 1'b0;
            end
            else
                evt_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        #RUN_LIMIT;
        $display("FAIL button_event_detector");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.func       = bed_pkg::FUNC_TICK;
        cmd_ch.key_levels = '0;
        evt_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;

        cfg_now.filter     = 8'd2;
        cfg_now.long_press = 16'd100;
        cfg_now.rpt_ticks  = 16'd10;
        cfg_now.combo      = 16'd30;
        cfg_now.max_hits   = 3'd4;
        cfg_now.rpt_mask   = 8'd0;
        cfg_now.quiet      = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
            keys[k] = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            event_ring[i] = '0;
        ring_wr = '0;
        ring_rd = '0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        // reset settings: empty read, no key, all keys, one key through the filter
        add_reads(1);
        add_ticks(8'h00, 1, 0);
        add_ticks(8'hFF, 1, 0);
        add_ticks(8'h80, 3, 0);
        add_ticks(8'h00, 3, 0);
        add_reads(2);
        wait_idle();

        // no filter, short long press, repeat every tick, quiet release, clamped hits
        set_config(0, 2, 0, 4, 7, 8'hFF, 1);
        add_ticks(8'h01, 4, 0);
        add_ticks(8'h00, 1, 0);
        add_ticks(8'h01, 1, 0);
        add_ticks(8'h00, 1, 0);
        add_ticks(8'h01, 1, 0);
        add_ticks(8'h00, 2, 0);
        add_reads(7);
        wait_idle();

        // receiver holds off while ticks and reads keep coming
        set_config(1, 12, 2, 12, 3, 8'hA5, 0);
        hold_requests++;
        run_phase(60, 35);

        // low extremes, rare reads so the queue overflows, no idling
        set_config(0, 0, 0, 1, 0, 8'hFF, 1);
        steady = 1'b1;
        run_phase(50, 10);
        steady = 1'b0;

        set_config($urandom_range(0, 3), $urandom_range(0, 30), $urandom_range(0, 6),
                   $urandom_range(1, 25), $urandom_range(0, 7), $urandom, $urandom_range(0, 1));
        hold_requests++;
        run_phase(60, 30);

        // high extremes, combo window zero wraps
        set_config(255, 65535, 65535, 0, 5, 8'h00, 0);
        run_phase(20, 30);

        // windows still running from the wrapped setting see a new combo value
        set_config($urandom_range(0, 2), $urandom_range(0, 20), $urandom_range(0, 4),
                   $urandom_range(1, 30), $urandom_range(0, 7), $urandom, $urandom_range(0, 1));
        run_phase(60, 40);

        set_config($urandom_range(0, 3), $urandom_range(0, 40), $urandom_range(0, 8),
                   $urandom_range(1, 65535), $urandom_range(2, 5), $urandom,
                   $urandom_range(0, 1));
        run_phase(50, 30);

        if (err_count == 0)
            $display("PASS button_event_detector");
        else
            $display("FAIL button_event_detector");
        $finish;
    end

endmodule
